FILE: src/orp_pkg.sv
// Shared types and field layout constants for the overwrite ring with playhead.
`timescale 1ns / 1ps

package orp_pkg;

  // Field widths of one input item and one result item.
  localparam int ENTRY_IN_W = 32;
  localparam int LIDX_W     = 6;
  localparam int DELTA_W    = 16;
  localparam int MODE_W     = 2;
  localparam int RDATA_W    = 32;
  localparam int FILL_W     = 7;
  localparam int SLOT_W     = 6;
  localparam int PLAY_W     = 6;

  // Number of distinct logical index codes.
  localparam int LIDX_N = 1 << LIDX_W;

  // Packed stream widths, rounded up to whole bytes.
  localparam int IN_FIELDS_W  = ENTRY_IN_W + LIDX_W + DELTA_W;
  localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = RDATA_W + FILL_W + SLOT_W + PLAY_W;
  localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

  typedef enum logic [MODE_W-1:0] {
    MODE_PUSH = 2'd0,
    MODE_READ = 2'd1,
    MODE_MOVE = 2'd2
  } orp_mode_t;

  // Ring status after one step, already cut to the result field widths.
  typedef struct packed {
    logic [PLAY_W-1:0] play;
    logic [SLOT_W-1:0] oldest;
    logic [FILL_W-1:0] fill;
  } orp_status_t;

endpackage

FILE: src/overwrite_ring_with_playhead.sv
// Top level of the overwrite ring with playhead: stream handshake and result register.
// Results: a result is valid in the cycle after its item is accepted.
// Throughput: one item per cycle unless out_tready stalls a held result; the
// result register and the memory's registered read port set this figure.
// Reset: rst_n clears the fill count, oldest slot, playhead and valid flags.
// The memory is not swept; slots beyond the fill count read as zero.
`timescale 1ns / 1ps

module overwrite_ring_with_playhead #(
  parameter int DEPTH   = 64,
  parameter int ENTRY_W = 32
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // Fields from bit 0: entry_data[31:0], logical_index[37:32], step_delta[53:38].
  input  logic [orp_pkg::IN_TDATA_W-1:0]  in_tdata,
  // Fields from bit 0: mode[1:0].
  input  logic [orp_pkg::MODE_W-1:0]      in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // Fields from bit 0: read_data[31:0], fill_count[38:32], oldest_slot[44:39],
  // playhead_pos[50:45].
  output logic [orp_pkg::OUT_TDATA_W-1:0] out_tdata
);

  localparam int AW = $clog2(DEPTH);

  logic                                step;
  orp_pkg::orp_mode_t                  mode;
  logic [orp_pkg::ENTRY_IN_W-1:0]      entry_data;
  logic [orp_pkg::LIDX_W-1:0]          logical_index;
  logic signed [orp_pkg::DELTA_W-1:0]  step_delta;

  logic                                wr_en;
  logic [AW-1:0]                       wr_addr;
  logic                                rd_en;
  logic [AW-1:0]                       rd_addr;
  logic                                rd_ok;
  orp_pkg::orp_status_t                status;
  orp_pkg::orp_status_t                status_r;
  logic [orp_pkg::RDATA_W-1:0]         read_data;
  logic                                out_valid_r;

  assign in_tready = !out_valid_r || out_tready;
  assign step      = in_tvalid && in_tready;

  assign mode          = orp_pkg::orp_mode_t'(in_tuser);
  assign entry_data    = in_tdata[orp_pkg::ENTRY_IN_W-1:0];
  assign logical_index = in_tdata[orp_pkg::ENTRY_IN_W +: orp_pkg::LIDX_W];
  assign step_delta    = $signed(in_tdata[orp_pkg::ENTRY_IN_W + orp_pkg::LIDX_W +:
                                          orp_pkg::DELTA_W]);

  orp_ctrl #(
    .DEPTH (DEPTH)
  ) u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (step),
    .mode    (mode),
    .lidx    (logical_index),
    .delta   (step_delta),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_ok   (rd_ok),
    .status  (status)
  );

  orp_store #(
    .DEPTH   (DEPTH),
    .ENTRY_W (ENTRY_W)
  ) u_store (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (step),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (ENTRY_W'(entry_data)),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_ok   (rd_ok),
    .rd_data (read_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_tready) begin
      out_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      status_r <= status;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(orp_pkg::OUT_TDATA_W - orp_pkg::OUT_FIELDS_W){1'b0}},
                       status_r.play, status_r.oldest, status_r.fill, read_data};

  a_result_follows_item : assert property (@(posedge clk) disable iff (!rst_n)
    step |=> out_tvalid)
    else $error("accepted item produced no result");

  a_no_read_data_without_read : assert property (@(posedge clk) disable iff (!rst_n)
    step && mode != orp_pkg::MODE_READ |=> out_tdata[orp_pkg::RDATA_W-1:0] == '0)
    else $error("read data present for an item that was not a read");

  a_stall_holds_status : assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(status_r))
    else $error("result status changed while stalled");

endmodule

FILE: src/orp_ctrl.sv
// Pointer control: oldest slot, fill count, playhead and memory addressing.
`timescale 1ns / 1ps

module orp_ctrl #(
  parameter int DEPTH = 64
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        step,
  input  orp_pkg::orp_mode_t          mode,
  input  logic [orp_pkg::LIDX_W-1:0]  lidx,
  input  logic signed [orp_pkg::DELTA_W-1:0] delta,
  output logic                        wr_en,
  output logic [$clog2(DEPTH)-1:0]    wr_addr,
  output logic                        rd_en,
  output logic [$clog2(DEPTH)-1:0]    rd_addr,
  output logic                        rd_ok,
  output orp_pkg::orp_status_t        status
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = ((AW > orp_pkg::DELTA_W) ? AW : orp_pkg::DELTA_W) + 2;
  localparam logic [CW-1:0] FULL      = CW'(DEPTH);
  localparam logic [AW:0]   DEPTH_EXT = (AW + 1)'(DEPTH);
  localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);

  logic [AW-1:0] oldest_r, oldest_nxt;
  logic [CW-1:0] held_r, held_nxt;
  logic [AW-1:0] play_r, play_nxt;

  logic [AW-1:0] lmod_tab [orp_pkg::LIDX_N];
  logic [AW:0]   rd_sum;
  logic [AW:0]   wr_sum;
  logic          full;
  logic signed [SW-1:0] np;
  logic signed [SW-1:0] held_s;

  // Logical index reduced modulo the depth, as a constant table.
  for (genvar g = 0; g < orp_pkg::LIDX_N; g++) begin : g_lmod
    assign lmod_tab[g] = AW'(g % DEPTH);
  end

  assign full   = (held_r == FULL);
  assign rd_sum = {1'b0, oldest_r} + {1'b0, lmod_tab[lidx]};
  assign wr_sum = {1'b0, oldest_r} + (AW + 1)'(held_r);
  assign np     = $signed({{(SW - AW){1'b0}}, play_r}) + SW'(delta);
  assign held_s = $signed({{(SW - CW){1'b0}}, held_r});

  always_comb begin
    rd_addr = (rd_sum >= DEPTH_EXT) ? AW'(rd_sum - DEPTH_EXT) : rd_sum[AW-1:0];
    // Slots are filled from slot 0 upward, so a slot below the fill count
    // has been written; once full every slot has been written.
    rd_ok   = full || ((CW + 1)'(rd_addr) < (CW + 1)'(held_r));
  end

  always_comb begin
    oldest_nxt = oldest_r;
    held_nxt   = held_r;
    play_nxt   = play_r;
    wr_en      = 1'b0;
    rd_en      = 1'b0;
    wr_addr    = (wr_sum >= DEPTH_EXT) ? AW'(wr_sum - DEPTH_EXT) : wr_sum[AW-1:0];
    case (mode)
      orp_pkg::MODE_PUSH: begin
        wr_en = step;
        if (full) begin
          wr_addr    = oldest_r;
          oldest_nxt = (oldest_r == LAST_SLOT) ? '0 : oldest_r + 1'b1;
        end else begin
          held_nxt = held_r + 1'b1;
        end
      end
      orp_pkg::MODE_READ: begin
        rd_en = step;
      end
      orp_pkg::MODE_MOVE: begin
        if (held_r == '0 || np < 0) begin
          play_nxt = '0;
        end else if (np >= held_s) begin
          play_nxt = AW'(held_r - 1'b1);
        end else begin
          play_nxt = np[AW-1:0];
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oldest_r <= '0;
      held_r   <= '0;
      play_r   <= '0;
    end else if (step) begin
      oldest_r <= oldest_nxt;
      held_r   <= held_nxt;
      play_r   <= play_nxt;
    end
  end

  always_comb begin
    status.fill   = orp_pkg::FILL_W'(held_nxt);
    status.oldest = orp_pkg::SLOT_W'(oldest_nxt);
    status.play   = orp_pkg::PLAY_W'(play_nxt);
  end

  a_held_bound : assert property (@(posedge clk) disable iff (!rst_n)
    held_r <= FULL)
    else $error("fill count above depth");

  a_oldest_only_when_full : assert property (@(posedge clk) disable iff (!rst_n)
    oldest_r != '0 |-> full)
    else $error("oldest slot moved before the ring filled");

  a_play_in_range : assert property (@(posedge clk) disable iff (!rst_n)
    (held_r == '0) ? (play_r == '0) : (CW'(play_r) < held_r))
    else $error("playhead outside held range");

  a_push_grows : assert property (@(posedge clk) disable iff (!rst_n)
    step && mode == orp_pkg::MODE_PUSH && !full |=> held_r == CW'($past(held_r) + 1'b1))
    else $error("push on a ring that is not full did not grow the fill count");

endmodule

FILE: src/orp_store.sv
// Entry memory with registered read and masking of never-written slots.
`timescale 1ns / 1ps

module orp_store #(
  parameter int DEPTH   = 64,
  parameter int ENTRY_W = 32
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         step,
  input  logic                         wr_en,
  input  logic [$clog2(DEPTH)-1:0]     wr_addr,
  input  logic [ENTRY_W-1:0]           wr_data,
  input  logic                         rd_en,
  input  logic [$clog2(DEPTH)-1:0]     rd_addr,
  input  logic                         rd_ok,
  output logic [orp_pkg::RDATA_W-1:0]  rd_data
);

  logic [ENTRY_W-1:0] mem [DEPTH];
  logic [ENTRY_W-1:0] rdata_r;
  logic               rd_ok_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_r <= mem[rd_addr];
    end
  end

  // Result shows memory data only for a read of a slot that has been written.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_ok_r <= 1'b0;
    end else if (step) begin
      rd_ok_r <= rd_en && rd_ok;
    end
  end

  assign rd_data = rd_ok_r ? orp_pkg::RDATA_W'(rdata_r) : '0;

endmodule

FILE: tb/orp_ring_checker.sv
// Checker for the overwrite ring with playhead: predicts each result and compares it.
`timescale 1ns / 1ps

module orp_ring_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  input  logic                            in_tready,
  // Fields from bit 0: entry_data[31:0], logical_index[37:32], step_delta[53:38].
  input  logic [orp_pkg::IN_TDATA_W-1:0]  in_tdata,
  // Fields from bit 0: mode[1:0].
  input  logic [orp_pkg::MODE_W-1:0]      in_tuser,
  input  logic                            out_tvalid,
  input  logic                            out_tready,
  // Fields from bit 0: read_data[31:0], fill_count[38:32], oldest_slot[44:39],
  // playhead_pos[50:45].
  input  logic [orp_pkg::OUT_TDATA_W-1:0] out_tdata,
  output int                              mismatch_count,
  output int                              reports_due
);

  localparam int RING_DEPTH  = 64;
  localparam int REPORT_SHOW = 10;

  typedef struct packed {
    logic [orp_pkg::RDATA_W-1:0] rdata;
    orp_pkg::orp_status_t        status;
  } ring_report_t;

  logic [orp_pkg::RDATA_W-1:0] ring_mem [RING_DEPTH];
  logic [orp_pkg::SLOT_W-1:0]  oldest_slot;
  logic [orp_pkg::FILL_W-1:0]  fill_count;
  logic [orp_pkg::PLAY_W-1:0]  play_pos;

  ring_report_t pending_reports[$];

  // Applies one item to the shadow ring and returns the report it should produce.
  function automatic ring_report_t apply_ring_op(
    input logic [orp_pkg::MODE_W-1:0]         op,
    input logic [orp_pkg::ENTRY_IN_W-1:0]     data,
    input logic [orp_pkg::LIDX_W-1:0]         idx,
    input logic signed [orp_pkg::DELTA_W-1:0] delta
  );
    ring_report_t rep;
    int           next_pos;
    logic [orp_pkg::SLOT_W-1:0] slot;
    rep = '0;
    case (op)
      orp_pkg::MODE_PUSH: begin
        if (fill_count < RING_DEPTH) begin
          slot = oldest_slot + fill_count[orp_pkg::SLOT_W-1:0];
          ring_mem[slot] = data;
          fill_count = fill_count + 1'b1;
        end else begin
          ring_mem[oldest_slot] = data;
          oldest_slot = oldest_slot + 1'b1;
        end
      end
      orp_pkg::MODE_READ: begin
        slot = oldest_slot + idx;
        rep.rdata = ring_mem[slot];
      end
      orp_pkg::MODE_MOVE: begin
        next_pos = int'(play_pos) + int'(delta);
        if (fill_count == 0 || next_pos < 0) begin
          play_pos = '0;
        end else if (next_pos >= int'(fill_count)) begin
          play_pos = orp_pkg::PLAY_W'(fill_count - 1'b1);
        end else begin
          play_pos = orp_pkg::PLAY_W'(next_pos);
        end
      end
      default: begin
        // The spare mode leaves the ring untouched.
      end
    endcase
    rep.status.fill   = fill_count;
    rep.status.oldest = oldest_slot;
    rep.status.play   = play_pos;
    return rep;
  endfunction

  always @(posedge clk) begin
    ring_report_t want;
    ring_report_t got;
    ring_report_t fresh;
    if (!rst_n) begin
      for (int i = 0; i < RING_DEPTH; i++) ring_mem[i] = '0;
      oldest_slot = '0;
      fill_count  = '0;
      play_pos    = '0;
      pending_reports.delete();
    end else begin
      // The result leaving now belongs to an older item, so compare before predicting.
      if (out_tvalid && out_tready) begin
        got.rdata  = out_tdata[orp_pkg::RDATA_W-1:0];
        got.status = orp_pkg::orp_status_t'(out_tdata[orp_pkg::RDATA_W +:
                       orp_pkg::FILL_W + orp_pkg::SLOT_W + orp_pkg::PLAY_W]);
        if (pending_reports.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_SHOW)
            $display("%0t: result with no item waiting: data %h fill %0d oldest %0d play %0d",
                     $realtime, got.rdata, got.status.fill, got.status.oldest,
                     got.status.play);
        end else begin
          want = pending_reports.pop_front();
          if (got.rdata !== want.rdata || got.status.fill !== want.status.fill ||
              got.status.oldest !== want.status.oldest ||
              got.status.play !== want.status.play) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_SHOW)
              $display({"%0t: result differs: data %h/%h fill %0d/%0d oldest %0d/%0d",
                        " play %0d/%0d (expected/actual)"},
                       $realtime, want.rdata, got.rdata, want.status.fill,
                       got.status.fill, want.status.oldest, got.status.oldest,
                       want.status.play, got.status.play);
          end
        end
      end
      if (in_tvalid && in_tready) begin
        fresh = apply_ring_op(
          in_tuser,
          in_tdata[orp_pkg::ENTRY_IN_W-1:0],
          in_tdata[orp_pkg::ENTRY_IN_W +: orp_pkg::LIDX_W],
          in_tdata[orp_pkg::ENTRY_IN_W + orp_pkg::LIDX_W +: orp_pkg::DELTA_W]);
        pending_reports = {pending_reports, fresh};
      end
    end
    reports_due = pending_reports.size();
  end

endmodule

FILE: tb/tb_overwrite_ring_with_playhead.sv
// Testbench top for the overwrite ring with playhead: stimulus, receiver stalls and verdict.
`timescale 1ns / 1ps

module tb_overwrite_ring_with_playhead;

  localparam logic [orp_pkg::MODE_W-1:0] MODE_SPARE = 2'd3;
  localparam int IDLE_LIMIT  = 5000;
  localparam int HOLD_CYCLES = 300;
  localparam int PHASE_ITEMS = 300;

  logic                            clk = 1'b0;
  logic                            rst_n;
  logic                            in_tvalid;
  logic                            in_tready;
  logic [orp_pkg::IN_TDATA_W-1:0]  in_tdata;
  logic [orp_pkg::MODE_W-1:0]      in_tuser;
  logic                            out_tvalid;
  logic                            out_tready;
  logic [orp_pkg::OUT_TDATA_W-1:0] out_tdata;

  int mismatch_count;
  int reports_due;
  int idle_cycles = 0;

  bit tx_steady = 1'b0;
  bit rx_steady = 1'b0;
  int hold_req  = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  overwrite_ring_with_playhead u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  orp_ring_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .in_tuser       (in_tuser),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .mismatch_count (mismatch_count),
    .reports_due    (reports_due)
  );

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  task automatic send_item(input logic [orp_pkg::MODE_W-1:0] op,
                           input logic [orp_pkg::ENTRY_IN_W-1:0] data,
                           input logic [orp_pkg::LIDX_W-1:0] idx,
                           input logic [orp_pkg::DELTA_W-1:0] delta);
    int gap;
    @(negedge clk);
    in_tuser  = op;
    in_tdata  = orp_pkg::IN_TDATA_W'({delta, idx, data});
    in_tvalid = 1'b1;
    do @(posedge clk); while (!in_tready);
    gap = tx_steady ? 0 : pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_tvalid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic send_random_item();
    logic [orp_pkg::MODE_W-1:0] op;
    logic [orp_pkg::DELTA_W-1:0] delta;
    int r;
    int d;
    r = $urandom_range(0, 99);
    if (r < 36) op = orp_pkg::MODE_PUSH;
    else if (r < 70) op = orp_pkg::MODE_READ;
    else if (r < 95) op = orp_pkg::MODE_MOVE;
    else op = MODE_SPARE;
    r = $urandom_range(0, 99);
    if (r < 70) begin
      d = int'($urandom_range(0, 140)) - 70;
      delta = d[orp_pkg::DELTA_W-1:0];
    end else begin
      delta = orp_pkg::DELTA_W'($urandom());
    end
    send_item(op, $urandom(), orp_pkg::LIDX_W'($urandom_range(0, orp_pkg::LIDX_N - 1)),
              delta);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_tvalid = 1'b0;
    wait (reports_due == 0);
  endtask

  // Receiver: random stalls, steady stretches, and one long hold-off on request.
  initial begin
    int stall_left;
    int holds_done;
    stall_left = 0;
    holds_done = 0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req != holds_done) begin
        holds_done = hold_req;
        out_tready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        out_tready = 1'b1;
      end else if (stall_left > 0) begin
        out_tready = 1'b0;
        stall_left--;
      end else begin
        out_tready = 1'b1;
        if (!rx_steady) stall_left = pick_gap();
      end
    end
  end

  // A run that stops making progress ends here.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles + 1 >= IDLE_LIMIT) begin
        $display("overwrite_ring_with_playhead: mismatch");
        $finish;
      end
    end
  end

  initial begin
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = orp_pkg::MODE_PUSH;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Empty ring: reads see cleared slots and moves keep the playhead at zero; then four pushes are read back.
    send_item(orp_pkg::MODE_READ, 32'h0, 6'd0, 16'h0);
    send_item(orp_pkg::MODE_READ, 32'h0, 6'd63, 16'h0);
    send_item(orp_pkg::MODE_MOVE, 32'h0, 6'd0, 16'h0005);
    send_item(orp_pkg::MODE_MOVE, 32'h0, 6'd0, 16'hFFFB);
    send_item(MODE_SPARE, 32'hFFFF_FFFF, 6'd63, 16'hFFFF);
    send_item(orp_pkg::MODE_PUSH, 32'h0000_0000, 6'd63, 16'h7FFF);
    send_item(orp_pkg::MODE_PUSH, 32'hFFFF_FFFF, 6'd0, 16'h8000);
    send_item(orp_pkg::MODE_PUSH, 32'hA5A5_A5A5, 6'd21, 16'h1234);
    send_item(orp_pkg::MODE_PUSH, 32'h5A5A_5A5A, 6'd42, 16'hEDCB);
    for (int i = 0; i < 4; i++)
      send_item(orp_pkg::MODE_READ, 32'h0, orp_pkg::LIDX_W'(i), 16'h0);
    // Indexes past the fill count still select a slot.
    send_item(orp_pkg::MODE_READ, 32'hFFFF_FFFF, 6'd4, 16'hFFFF);
    send_item(orp_pkg::MODE_READ, 32'h0, 6'd63, 16'h0);
    send_item(orp_pkg::MODE_MOVE, 32'h0, 6'd0, 16'h7FFF);
    send_item(orp_pkg::MODE_MOVE, 32'h0, 6'd0, 16'h0000);
    send_item(orp_pkg::MODE_MOVE, 32'h0, 6'd0, 16'h8000);
    send_item(orp_pkg::MODE_MOVE, 32'h0, 6'd0, 16'h0001);
    send_item(orp_pkg::MODE_MOVE, 32'hFFFF_FFFF, 6'd63, 16'hFFFF);
    send_item(orp_pkg::MODE_MOVE, 32'h0, 6'd0, 16'h0002);
    // A push leaves the playhead where it is.
    send_item(orp_pkg::MODE_PUSH, 32'h1357_9BDF, 6'd0, 16'h0);
    send_item(MODE_SPARE, 32'h0, 6'd0, 16'h0);
    wait_drained();

    // Back-to-back traffic with the receiver always ready.
    tx_steady = 1'b1;
    rx_steady = 1'b1;
    repeat (PHASE_ITEMS) send_random_item();

    tx_steady = 1'b0;
    rx_steady = 1'b0;
    repeat (PHASE_ITEMS) send_random_item();

    // The receiver holds off while items keep coming, so the input stalls.
    tx_steady = 1'b1;
    hold_req  = hold_req + 1;
    repeat (40) send_random_item();
    tx_steady = 1'b0;
    wait_drained();

    repeat (PHASE_ITEMS) send_random_item();
    rx_steady = 1'b1;
    repeat (PHASE_ITEMS / 2) send_random_item();
    rx_steady = 1'b0;

    wait_drained();
    repeat (4) @(posedge clk);
    if (mismatch_count == 0 && reports_due == 0) begin
      $display("overwrite_ring_with_playhead: match");
    end else begin
      $display("overwrite_ring_with_playhead: mismatch");
    end
    $finish;
  end

endmodule
